// ----- sv/sliding_window_patch_extract_assert.svh -----
// Assertion macros shared by the patch extractor modules.
`ifndef SLIDING_WINDOW_PATCH_EXTRACT_ASSERT_SVH
`define SLIDING_WINDOW_PATCH_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SWPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/swpe_pkg.sv -----
// Shared types and constants of the sliding window patch extractor.
`default_nettype none

package swpe_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_KERNEL = 8;

	localparam int CFG_DIM_W  = 11;
	localparam int CFG_K_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 2'd3;

	localparam int PIXEL_W = 32;
	localparam int PATCH_W = 24;
	localparam int ELEM_W  = 6;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               first;
	} swpe_in_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] value;
		logic [PATCH_W-1:0] patch_row;
		logic [ELEM_W-1:0]  elem_index;
		logic               last;
	} swpe_out_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic read;
	} swpe_cmd_t;

	typedef struct packed {
		logic emit;
		logic last_elem;
		logic out_free;
	} swpe_status_t;

endpackage

`default_nettype wire

// ----- sv/sliding_window_patch_extract.sv -----
// Sliding window patch extractor (im2col, valid windows, stride one), top level.
// Pixels enter on the in channel (valid/ready, payload in_data) in raster order,
// images of a batch back to back; in_data.first restarts the row, column and patch
// counters. For each pixel that completes a kernel window, the window's words leave
// on the out channel in row-major window order, tagged with the patch number and
// element index, with last set on the final word. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no pixel is in
// flight, as the block does not enforce this. A pixel transfer is followed by a
// setup state; a pixel that completes no window then returns to idle and frees the
// input. A completing pixel reads one window word per cycle while the output is
// free, from the row store's single read port, the first read after setup loading
// the output register. When the receiver stalls, the output register holds its word
// and the reads pause until it is taken; the input stays not ready meanwhile.
// Reset clears the counters and loads an 8x8 image with a 3x3 kernel. The row
// store is not cleared and needs no clearing pass; it is written before it is read.
`default_nettype none

module sliding_window_patch_extract #(
	parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = swpe_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = swpe_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [swpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swpe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire swpe_pkg::swpe_in_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output swpe_pkg::swpe_out_t                  out_data
);
	import swpe_pkg::*;

	swpe_cmd_t    cmd;
	swpe_status_t status;

	swpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	swpe_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_KERNEL (MAX_KERNEL)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- sv/swpe_ctrl.sv -----
// Controller state machine of the sliding window patch extractor.
`default_nettype none
`include "sliding_window_patch_extract_assert.svh"

module swpe_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire swpe_pkg::swpe_status_t status,
	output swpe_pkg::swpe_cmd_t        cmd
);
	import swpe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.read   = (state_q == ST_READ) && status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = status.emit ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				if (cmd.read && status.last_elem) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SWPE_ASSERT_NOW(a_load_after_transfer, state_q == ST_LOAD, $past(in_valid && in_ready), "window setup without an input transfer")
	`SWPE_ASSERT_NEXT(a_setup_follows, cmd.accept, state_q == ST_LOAD, "no window setup after an input transfer")
	`SWPE_ASSERT_NEXT(a_ready_after_window, cmd.read && status.last_elem, in_ready, "not ready after the final window word")

endmodule

`default_nettype wire

// ----- sv/swpe_datapath.sv -----
// Datapath of the sliding window patch extractor: counters, row store and output register.
`default_nettype none
`include "sliding_window_patch_extract_assert.svh"

module swpe_datapath #(
	parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = swpe_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = swpe_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [swpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [swpe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire swpe_pkg::swpe_in_t                  in_data,
	input  wire swpe_pkg::swpe_cmd_t                 cmd,
	output swpe_pkg::swpe_status_t                   status,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output swpe_pkg::swpe_out_t                      out_data
);
	import swpe_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int SW  = $clog2(MAX_KERNEL);
	localparam int SXW = SW + 2;
	localparam int WCW = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
	localparam int HCW = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;
	localparam int RXW = RW + CFG_K_W;
	localparam int CXW = CW + CFG_K_W;

	logic [CFG_DIM_W-1:0] img_h_q;
	logic [CFG_DIM_W-1:0] img_w_q;
	logic [CFG_K_W-1:0]   ker_h_q;
	logic [CFG_K_W-1:0]   ker_w_q;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [SW-1:0]      slot_q;
	logic [PATCH_W-1:0] patch_q;

	logic [SW-1:0]      rd_slot_q;
	logic [CW-1:0]      rd_col_q;
	logic [CW-1:0]      start_col_q;
	logic [CFG_K_W-1:0] ky_q;
	logic [CFG_K_W-1:0] kx_q;
	logic [ELEM_W-1:0]  elem_q;

	logic               out_valid_q;
	logic [PIXEL_W-1:0] store_q [MAX_KERNEL][MAX_WIDTH];
	logic [PIXEL_W-1:0] value_q;
	logic [PATCH_W-1:0] tag_patch_q;
	logic [ELEM_W-1:0]  tag_elem_q;
	logic               tag_last_q;

	logic [WCW-1:0]     w_ext;
	logic [HCW-1:0]     h_ext;
	logic [WW-1:0]      w_cl;
	logic [HW-1:0]      h_cl;
	logic [CFG_K_W-1:0] kh_m1;
	logic [CFG_K_W-1:0] kw_m1;
	logic               kernel_ok;

	logic [CW-1:0]      a_col;
	logic [RW-1:0]      a_row;
	logic [SW-1:0]      a_slot;
	logic               a_wrap_col;
	logic [CW-1:0]      b_col;
	logic [HW-1:0]      b_row;
	logic [SW-1:0]      b_slot;
	logic               b_wrap_row;
	logic [RW-1:0]      c_row;
	logic [SW-1:0]      c_slot;

	logic [WW-1:0]      n_col_inc;
	logic [HW-1:0]      n_row_inc;
	logic [SXW-1:0]     start_slot_x;
	logic [SXW-1:0]     start_slot_w;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		slot_next = (s == SW'(MAX_KERNEL - 1)) ? '0 : s + SW'(1);
	endfunction

	// Image dimensions in use are clamped to one and to the build maximum.
	assign w_ext = WCW'(img_w_q);
	assign h_ext = HCW'(img_h_q);
	assign w_cl  = (w_ext == '0) ? WW'(1) :
		((w_ext > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext));
	assign h_cl  = (h_ext == '0) ? HW'(1) :
		((h_ext > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_ext));

	assign kh_m1 = ker_h_q - CFG_K_W'(1);
	assign kw_m1 = ker_w_q - CFG_K_W'(1);
	assign kernel_ok = (ker_h_q != '0) && (ker_w_q != '0)
		&& (ker_h_q <= CFG_K_W'(MAX_KERNEL)) && (ker_w_q <= CFG_K_W'(MAX_KERNEL))
		&& (HCW'(ker_h_q) <= HCW'(h_cl)) && (WCW'(ker_w_q) <= WCW'(w_cl));

	// Position of the incoming pixel after a batch restart and any wrap left by a
	// configuration change.
	assign a_col      = in_data.first ? '0 : col_q;
	assign a_row      = in_data.first ? '0 : row_q;
	assign a_slot     = in_data.first ? '0 : slot_q;
	assign a_wrap_col = (WW'(a_col) >= w_cl);
	assign b_col      = a_wrap_col ? '0 : a_col;
	assign b_row      = a_wrap_col ? (HW'(a_row) + HW'(1)) : HW'(a_row);
	assign b_slot     = a_wrap_col ? slot_next(a_slot) : a_slot;
	assign b_wrap_row = (b_row >= h_cl);
	assign c_row      = b_wrap_row ? '0 : RW'(b_row);
	assign c_slot     = b_wrap_row ? '0 : b_slot;

	assign n_col_inc = WW'(col_q) + WW'(1);
	assign n_row_inc = HW'(row_q) + HW'(1);

	assign start_slot_x = SXW'(slot_q) + SXW'(MAX_KERNEL) - SXW'(kh_m1);
	assign start_slot_w = (start_slot_x >= SXW'(MAX_KERNEL)) ?
		(start_slot_x - SXW'(MAX_KERNEL)) : start_slot_x;

	assign status.emit      = kernel_ok && (RXW'(row_q) >= RXW'(kh_m1))
		&& (CXW'(col_q) >= CXW'(kw_m1));
	assign status.last_elem = (kx_q == kw_m1) && (ky_q == kh_m1);
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_h_q <= CFG_DIM_W'(8);
			img_w_q <= CFG_DIM_W'(8);
			ker_h_q <= CFG_K_W'(3);
			ker_w_q <= CFG_K_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data[CFG_DIM_W-1:0];
				CFG_IMAGE_WIDTH:   img_w_q <= cfg_data[CFG_DIM_W-1:0];
				CFG_KERNEL_HEIGHT: ker_h_q <= cfg_data[CFG_K_W-1:0];
				CFG_KERNEL_WIDTH:  ker_w_q <= cfg_data[CFG_K_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			patch_q <= '0;
		end else if (cmd.accept) begin
			col_q  <= b_col;
			row_q  <= c_row;
			slot_q <= c_slot;
			if (in_data.first) begin
				patch_q <= '0;
			end
		end else if (cmd.load) begin
			if (n_col_inc >= w_cl) begin
				col_q <= '0;
				if (n_row_inc >= h_cl) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= RW'(n_row_inc);
					slot_q <= slot_next(slot_q);
				end
			end else begin
				col_q <= CW'(n_col_inc);
			end
		end else if (cmd.read && status.last_elem) begin
			patch_q <= patch_q + PATCH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_slot_q   <= SW'(start_slot_w);
			rd_col_q    <= col_q - CW'(kw_m1);
			start_col_q <= col_q - CW'(kw_m1);
			ky_q        <= '0;
			kx_q        <= '0;
			elem_q      <= '0;
		end else if (cmd.read) begin
			elem_q <= elem_q + ELEM_W'(1);
			if (kx_q == kw_m1) begin
				kx_q      <= '0;
				ky_q      <= ky_q + CFG_K_W'(1);
				rd_col_q  <= start_col_q;
				rd_slot_q <= slot_next(rd_slot_q);
			end else begin
				kx_q     <= kx_q + CFG_K_W'(1);
				rd_col_q <= rd_col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			store_q[c_slot][b_col] <= in_data.pixel;
		end
		if (cmd.read) begin
			value_q     <= store_q[rd_slot_q][rd_col_q];
			tag_patch_q <= patch_q;
			tag_elem_q  <= elem_q;
			tag_last_q  <= status.last_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_data.value      = value_q;
	assign out_data.patch_row  = tag_patch_q;
	assign out_data.elem_index = tag_elem_q;
	assign out_data.last       = tag_last_q;

	`SWPE_ASSERT_NOW(a_no_read_on_write, cmd.accept, !cmd.read, "row store written and read in one cycle")
	`SWPE_ASSERT_NEXT(a_col_in_image, cmd.accept, WW'(col_q) < $past(w_cl), "column counter outside the image")
	`SWPE_ASSERT_NEXT(a_last_marked, cmd.read && status.last_elem, out_valid_q && tag_last_q, "final window word not marked")

endmodule

`default_nettype wire
